/* rtl/dtd_pkg.sv */
// package: constants, register indexes and sequencer states of the dissolve detector
package dtd_pkg;

  localparam int DARK_WINDOW      = 10;
  localparam int FRAME_INDEX_BITS = 20;
  localparam int LOOKAHEAD        = (DARK_WINDOW - 1) > 3 ? (DARK_WINDOW - 1) : 3;
  localparam int LUMA_DEPTH       = 2 * LOOKAHEAD + 1;
  localparam int LUMA_CTR         = LOOKAHEAD;
  localparam int VAR_DEPTH        = LOOKAHEAD + 3;
  localparam int VAR_CTR          = 2;
  localparam int PEND_W           = $clog2(LOOKAHEAD + 2);
  localparam int CNT_W            = $clog2(DARK_WINDOW + 1);

  localparam int LUMA_W  = 16;
  localparam int VAR_W   = 22;
  localparam int THR_W   = 31;
  localparam int LIMIT_W = 5;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;

  localparam int MAG_W  = 23;
  localparam int DEN_W  = 16;
  localparam int FRAC_W = 15;
  localparam int NUM_W  = MAG_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [THR_W-1:0] RATIO_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LEVEL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT      = 2'd2;

  localparam logic [THR_W-1:0]   THR_RESET   = 31'd131072;
  localparam logic [LUMA_W-1:0]  LEVEL_RESET = 16'd2560;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_LOAD,
    S_DIV,
    S_EMIT
  } state_e;

endpackage

/* rtl/dtd_if.sv */
// interfaces: frame input channel and verdict output channel
interface dtd_in_if import dtd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] mean_luma;
  logic [VAR_W-1:0]  diag_variance;
  logic              final_frame;

  modport source (output valid, mean_luma, diag_variance, final_frame, input ready);
  modport sink   (input valid, mean_luma, diag_variance, final_frame, output ready);
endinterface

interface dtd_out_if import dtd_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [FRAME_INDEX_BITS-1:0] frame_number;
  logic                        is_dissolve;
  logic                        last_verdict;

  modport source (output valid, frame_number, is_dissolve, last_verdict, input ready);
  modport sink   (input valid, frame_number, is_dissolve, last_verdict, output ready);
endinterface

/* rtl/dissolve_transition_detector.sv */
// top level: dissolve detector with frame windows and a shared serial divider
//
//   channel  | dir | payload                                     | handshake
//   in_i     | in  | mean_luma, diag_variance, final_frame       | valid/ready
//   out_o    | out | frame_number, is_dissolve, last_verdict     | valid/ready
//   cfg      | in  | cfg_idx_i, cfg_data_i                       | cfg_we_i
//
// a verdict runs two divisions in the restoring divider (38 quotient bits each, one
// per cycle; a division is skipped when a term is zero) and is then offered on out_o.
// on a final frame up to ten verdicts follow, after blank frames are shifted in to align.
// reset clears the control state and sets the config registers to their defaults.
// in_i is not ready while a verdict is in work or waits on out_o.
module dissolve_transition_detector import dtd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dtd_in_if.sink               in_i,
  dtd_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  state_e state_q, state_d;

  logic [THR_W-1:0]   thr_q;
  logic [LUMA_W-1:0]  level_q;
  logic [LIMIT_W-1:0] limit_q;

  logic [LUMA_W-1:0] lum_q [LUMA_DEPTH];
  logic [VAR_W-1:0]  var_q [VAR_DEPTH];
  logic [LUMA_DEPTH-1:0] zf_q;

  logic [FRAME_INDEX_BITS-1:0] seen_q, cur_q;
  logic [PEND_W-1:0] pend_q, fill_q;
  logic flush_q, sel_q;

  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q, rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [THR_W-1:0]     r0_q;

  logic out_dis_q, out_last_q;
  logic [FRAME_INDEX_BITS-1:0] out_frame_q;

  logic in_fire, out_fire;
  logic shift_en;
  logic [LUMA_W-1:0] shift_l;
  logic [VAR_W-1:0]  shift_v;
  logic              shift_z;

  // window arithmetic
  logic e1, e2;
  logic signed [LUMA_W:0]  dl0, dl1;
  logic signed [VAR_W:0]   dvm1, dv0, dv1, dv2;
  logic signed [VAR_W+1:0] d20, d21;
  logic [VAR_W+1:0] a0_abs, a1_abs;
  logic [LUMA_W:0]  b0_abs, b1_abs;
  logic [MAG_W-1:0] a_sel;
  logic [DEN_W-1:0] b_sel;
  logic load_zero;

  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W-1:0] rem_nx;
  logic [NUM_W-1:0] quot;
  logic [THR_W-1:0] ratio;
  logic             div_last;

  logic [CNT_W-1:0] next_cnt, prev_cnt;
  logic             alive;
  logic [THR_W-1:0] diff, r1_use;
  logic             dis;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      level_q <= LEVEL_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RATIO_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_DARK_LEVEL:      level_q <= cfg_data_i[LUMA_W-1:0];
        CFG_DARK_LIMIT:      limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // shift source: a new frame, or a blank frame past the end of the video
  always_comb begin
    shift_en = 1'b0;
    shift_l  = '0;
    shift_v  = '0;
    shift_z  = 1'b0;
    if (in_fire) begin
      shift_en = 1'b1;
      shift_l  = in_i.mean_luma;
      shift_v  = in_i.diag_variance;
      shift_z  = (seen_q == '0);
    end else if (state_q == S_FILL) begin
      shift_en = 1'b1;
    end else if (state_q == S_EMIT && out_fire && flush_q) begin
      shift_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int j = 0; j < LUMA_DEPTH - 1; j++) lum_q[j] <= lum_q[j+1];
      lum_q[LUMA_DEPTH-1] <= shift_l;
      for (int k = 0; k < VAR_DEPTH - 1; k++) var_q[k] <= var_q[k+1];
      var_q[VAR_DEPTH-1] <= shift_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zf_q <= '0;
    end else if (shift_en) begin
      zf_q <= {shift_z, zf_q[LUMA_DEPTH-1:1]};
    end
  end

  // derivatives around the frame under judgement
  assign e1 = pend_q >= PEND_W'(2);
  assign e2 = pend_q >= PEND_W'(3);

  always_comb begin
    dl0 = zf_q[LUMA_CTR] ? -$signed({1'b0, lum_q[LUMA_CTR]})
        : $signed({1'b0, lum_q[LUMA_CTR+1]}) - $signed({1'b0, lum_q[LUMA_CTR-1]});
    dl1 = !e1 ? '0
        : zf_q[LUMA_CTR+1] ? -$signed({1'b0, lum_q[LUMA_CTR+1]})
        : $signed({1'b0, lum_q[LUMA_CTR+2]}) - $signed({1'b0, lum_q[LUMA_CTR]});
    dvm1 = zf_q[LUMA_CTR-1] ? -$signed({1'b0, var_q[VAR_CTR-1]})
         : $signed({1'b0, var_q[VAR_CTR]}) - $signed({1'b0, var_q[VAR_CTR-2]});
    dv0 = zf_q[LUMA_CTR] ? -$signed({1'b0, var_q[VAR_CTR]})
        : $signed({1'b0, var_q[VAR_CTR+1]}) - $signed({1'b0, var_q[VAR_CTR-1]});
    dv1 = !e1 ? '0
        : zf_q[LUMA_CTR+1] ? -$signed({1'b0, var_q[VAR_CTR+1]})
        : $signed({1'b0, var_q[VAR_CTR+2]}) - $signed({1'b0, var_q[VAR_CTR]});
    dv2 = !e2 ? '0
        : zf_q[LUMA_CTR+2] ? -$signed({1'b0, var_q[VAR_CTR+2]})
        : $signed({1'b0, var_q[VAR_CTR+3]}) - $signed({1'b0, var_q[VAR_CTR+1]});
    d20 = zf_q[LUMA_CTR] ? -$signed({dv0[VAR_W], dv0})
        : $signed({dv1[VAR_W], dv1}) - $signed({dvm1[VAR_W], dvm1});
    d21 = !e1 ? '0
        : zf_q[LUMA_CTR+1] ? -$signed({dv1[VAR_W], dv1})
        : $signed({dv2[VAR_W], dv2}) - $signed({dv0[VAR_W], dv0});
    a0_abs = d20[VAR_W+1] ? $unsigned(-d20) : $unsigned(d20);
    a1_abs = d21[VAR_W+1] ? $unsigned(-d21) : $unsigned(d21);
    b0_abs = dl0[LUMA_W] ? $unsigned(-dl0) : $unsigned(dl0);
    b1_abs = dl1[LUMA_W] ? $unsigned(-dl1) : $unsigned(dl1);
    a_sel = sel_q ? a1_abs[MAG_W-1:0] : a0_abs[MAG_W-1:0];
    b_sel = sel_q ? b1_abs[DEN_W-1:0] : b0_abs[DEN_W-1:0];
    load_zero = (a_sel == '0) || (b_sel == '0);
  end

  // restoring divider step
  always_comb begin
    rem_sh   = {rem_q, num_q[NUM_W-1]};
    q_bit    = rem_sh >= {1'b0, den_q};
    rem_nx   = q_bit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    quot     = {num_q[NUM_W-2:0], q_bit};
    ratio    = (|quot[NUM_W-1:THR_W]) ? RATIO_MAX : quot[THR_W-1:0];
    div_last = cnt_q == DIV_CNT_W'(1);
  end

  // dark frame windows
  always_comb begin
    next_cnt = '0;
    prev_cnt = '0;
    alive    = 1'b1;
    for (int i = 0; i < DARK_WINDOW; i++) begin
      if ((PEND_W'(i) < pend_q) && (lum_q[LUMA_CTR+i] < level_q)) begin
        next_cnt = next_cnt + CNT_W'(1);
      end
    end
    for (int i = 0; i < DARK_WINDOW; i++) begin
      if (zf_q[LUMA_CTR-i]) alive = 1'b0;
      if (alive && (lum_q[LUMA_CTR-i] < level_q)) prev_cnt = prev_cnt + CNT_W'(1);
    end
  end

  always_comb begin
    r1_use = (state_q == S_LOAD) ? '0 : ratio;
    diff   = (r1_use > r0_q) ? r1_use - r0_q : r0_q - r1_use;
    dis    = (diff <= thr_q) && ({1'b0, next_cnt} < limit_q) && ({1'b0, prev_cnt} < limit_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.final_frame) begin
            state_d = (pend_q == PEND_W'(LOOKAHEAD)) ? S_LOAD : S_FILL;
          end else if (pend_q == PEND_W'(LOOKAHEAD)) begin
            state_d = S_LOAD;
          end
        end
      end
      S_FILL: begin
        if (fill_q == PEND_W'(1)) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (load_zero) state_d = sel_q ? S_EMIT : S_LOAD;
        else           state_d = S_DIV;
      end
      S_DIV: begin
        if (div_last) state_d = sel_q ? S_EMIT : S_LOAD;
      end
      S_EMIT: begin
        if (out_fire) state_d = (flush_q && pend_q != PEND_W'(1)) ? S_LOAD : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready         = (state_q == S_IDLE);
    out_o.valid        = (state_q == S_EMIT);
    out_o.frame_number = out_frame_q;
    out_o.is_dissolve  = out_dis_q;
    out_o.last_verdict = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seen_q  <= '0;
      cur_q   <= '0;
      pend_q  <= '0;
      fill_q  <= '0;
      flush_q <= 1'b0;
      sel_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            seen_q <= seen_q + FRAME_INDEX_BITS'(1);
            pend_q <= pend_q + PEND_W'(1);
            fill_q <= PEND_W'(LOOKAHEAD) - pend_q;
            sel_q  <= 1'b0;
            if (in_i.final_frame) flush_q <= 1'b1;
          end
        end
        S_FILL: begin
          fill_q <= fill_q - PEND_W'(1);
        end
        S_LOAD: begin
          cnt_q <= DIV_CNT_W'(NUM_W);
          if (load_zero) sel_q <= ~sel_q;
        end
        S_DIV: begin
          cnt_q <= cnt_q - DIV_CNT_W'(1);
          if (div_last) sel_q <= ~sel_q;
        end
        S_EMIT: begin
          if (out_fire) begin
            cur_q  <= cur_q + FRAME_INDEX_BITS'(1);
            pend_q <= pend_q - PEND_W'(1);
            if (flush_q && pend_q == PEND_W'(1)) begin
              seen_q  <= '0;
              cur_q   <= '0;
              flush_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // divider and verdict payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      num_q <= {a_sel, FRAC_W'(0)};
      den_q <= b_sel;
      rem_q <= '0;
      if (load_zero) begin
        if (!sel_q) begin
          r0_q <= '0;
        end else begin
          out_dis_q   <= dis;
          out_frame_q <= cur_q;
          out_last_q  <= flush_q && (pend_q == PEND_W'(1));
        end
      end
    end else if (state_q == S_DIV) begin
      num_q <= quot;
      rem_q <= rem_nx;
      if (div_last) begin
        if (!sel_q) begin
          r0_q <= ratio;
        end else begin
          out_dis_q   <= dis;
          out_frame_q <= cur_q;
          out_last_q  <= flush_q && (pend_q == PEND_W'(1));
        end
      end
    end
  end

endmodule

/* rtl/dtd_checker.sv */
// checker: port-level properties of the dissolve detector, bound to the top level
module dtd_checker import dtd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_final_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i
);

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a verdict is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("verdict dropped before transfer");

  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> !in_ready_i)
    else $error("final frame produced no flush");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> in_ready_i && !out_valid_i)
    else $error("no return to idle after last verdict");

endmodule

bind dissolve_transition_detector dtd_checker u_dtd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_final_i  (in_i.final_frame),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last_verdict)
);

/* sim/testbench.sv */
// testbench: dissolve detector checked against a frame-accurate verdict predictor
`timescale 1ns / 1ps

module testbench import dtd_pkg::*;;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic [VAR_W-1:0]  variance;
    logic              last;
  } frame_t;

  typedef struct packed {
    logic [FRAME_INDEX_BITS-1:0] number;
    logic                        dissolve;
    logic                        last;
  } verdict_t;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int IDX_MASK     = (1 << FRAME_INDEX_BITS) - 1;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  dtd_in_if  in_ch ();
  dtd_out_if out_ch ();

  dissolve_transition_detector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  frame_t   frame_queue[$];
  verdict_t verdict_queue[$];
  int send_idle, recv_idle;
  bit hold_frames;
  int errors, verdict_count, dissolve_count, video_count;
  int unsigned cycles;

  // predictor state
  logic [LUMA_W-1:0] luma_ring[64];
  logic [VAR_W-1:0]  var_ring[64];
  int unsigned frames_in, verdicts_out, judged;
  int span;
  longint unsigned thr_q;
  longint unsigned level_q;
  int unsigned limit_q;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pos_at(int o);
    return (judged + o) & IDX_MASK;
  endfunction

  function automatic longint luma_at(int o);
    if (o >= span) return 0;
    return luma_ring[pos_at(o) & 63];
  endfunction

  function automatic longint var_at(int o);
    if (o >= span) return 0;
    return var_ring[pos_at(o) & 63];
  endfunction

  function automatic longint luma_slope(int o);
    if (o >= span) return 0;
    if (pos_at(o) == 0) return -luma_at(o);
    return luma_at(o + 1) - luma_at(o - 1);
  endfunction

  function automatic longint var_slope(int o);
    if (o >= span) return 0;
    if (pos_at(o) == 0) return -var_at(o);
    return var_at(o + 1) - var_at(o - 1);
  endfunction

  function automatic longint var_curve(int o);
    if (o >= span) return 0;
    if (pos_at(o) == 0) return -var_slope(o);
    return var_slope(o + 1) - var_slope(o - 1);
  endfunction

  function automatic longint unsigned ratio_abs(int o);
    longint a, b;
    longint unsigned q;
    if (o >= span) return 0;
    a = var_curve(o);
    b = luma_slope(o);
    if (a == 0 || b == 0) return 0;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    q = (a * 32768) / b;
    return (q > 64'h7FFFFFFF) ? 64'h7FFFFFFF : q;
  endfunction

  function automatic verdict_t judge(bit last);
    longint unsigned r0, r1, diff;
    int unsigned dark_ahead, dark_behind;
    verdict_t v;
    r0 = ratio_abs(0);
    r1 = ratio_abs(1);
    diff = (r1 > r0) ? r1 - r0 : r0 - r1;
    dark_ahead = 0;
    dark_behind = 0;
    for (int o = 0; o < DARK_WINDOW && o < span; o++)
      if (luma_at(o) < level_q) dark_ahead++;
    for (int o = 0; o > -DARK_WINDOW; o--) begin
      if (pos_at(o) == 0) break;
      if (luma_at(o) < level_q) dark_behind++;
    end
    v.number = judged[FRAME_INDEX_BITS-1:0];
    v.dissolve = diff <= thr_q && dark_ahead < limit_q && dark_behind < limit_q;
    v.last = last;
    return v;
  endfunction

  task automatic predict_frame(frame_t f);
    int unsigned waiting;
    luma_ring[frames_in & 63] = f.luma;
    var_ring[frames_in & 63] = f.variance;
    frames_in = (frames_in + 1) & IDX_MASK;
    waiting = (frames_in - verdicts_out) & IDX_MASK;
    if (f.last) begin
      while (waiting > 0) begin
        judged = verdicts_out;
        span = waiting;
        verdict_queue.insert(verdict_queue.size(), judge(waiting == 1));
        verdicts_out = (verdicts_out + 1) & IDX_MASK;
        waiting--;
      end
      frames_in = 0;
      verdicts_out = 0;
    end else if (waiting > LOOKAHEAD) begin
      judged = verdicts_out;
      span = waiting;
      verdict_queue.insert(verdict_queue.size(), judge(1'b0));
      verdicts_out = (verdicts_out + 1) & IDX_MASK;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mean_luma <= '0;
      in_ch.diag_variance <= '0;
      in_ch.final_frame <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_ch.ready) begin
        if (frame_queue.size() > 0 && !hold_frames && $urandom_range(99) >= send_idle) begin
          frame_t f;
          f = frame_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mean_luma <= f.luma;
          in_ch.diag_variance <= f.variance;
          in_ch.final_frame <= f.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (in_ch.valid && in_ch.ready)
        predict_frame({in_ch.mean_luma, in_ch.diag_variance, in_ch.final_frame});
      if (out_ch.valid && out_ch.ready) begin
        verdict_t got, want;
        got = {out_ch.frame_number, out_ch.is_dissolve, out_ch.last_verdict};
        if (verdict_queue.size() == 0) begin
          $display("%0t: unexpected verdict %h", $time, got);
          errors++;
        end else begin
          want = verdict_queue.pop_front();
          verdict_count++;
          if (got.dissolve) dissolve_count++;
          if (got.number !== want.number)
            $display("%0t: frame_number expected %0d actual %0d", $time, want.number, got.number);
          if (got.dissolve !== want.dissolve)
            $display("%0t: is_dissolve frame %0d expected %0b actual %0b", $time,
                     want.number, want.dissolve, got.dissolve);
          if (got.last !== want.last)
            $display("%0t: last_verdict frame %0d expected %0b actual %0b", $time,
                     want.number, want.last, got.last);
          if (got !== want) errors++;
        end
      end
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic add_frame(int luma, int variance, bit last);
    frame_t f;
    f.luma = (luma < 0) ? 16'd0 : (luma > 65535) ? 16'hFFFF : luma[15:0];
    f.variance = (variance < 0) ? 22'd0 : (variance > 4194303) ? 22'h3FFFFF : variance[21:0];
    f.last = last;
    frame_queue.insert(frame_queue.size(), f);
    if (last) video_count++;
  endtask

  task automatic drain();
    wait (frame_queue.size() == 0 && !in_ch.valid && verdict_queue.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RATIO_THRESHOLD: thr_q = data[THR_W-1:0];
      CFG_DARK_LEVEL:      level_q = data[LUMA_W-1:0];
      CFG_DARK_LIMIT:      limit_q = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // one video: fade-like ramps, noise or dark stretches
  task automatic add_video(int frames);
    int kind, base, slope, curve, vbase, center;
    kind = $urandom_range(9);
    base = $urandom_range(65535);
    slope = $urandom_range(1200) - 600;
    curve = $urandom_range(600);
    vbase = $urandom_range(4194303);
    center = $urandom_range(frames);
    for (int k = 0; k < frames; k++) begin
      if (kind < 6)
        add_frame(base + k * slope, vbase / 4 + curve * (k - center) * (k - center),
                  k == frames - 1);
      else if (kind < 8)
        add_frame($urandom_range(65535), $urandom_range(4194303), k == frames - 1);
      else
        add_frame(($urandom_range(2) == 0) ? $urandom_range(65535) : $urandom_range(3000),
                  $urandom_range(4194303), k == frames - 1);
    end
  endtask

  task automatic random_videos(int items);
    int n, len;
    n = 0;
    while (n < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(25, 3);
      add_video(len);
      n += len;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    hold_frames = 1'b0;
    errors = 0;
    verdict_count = 0;
    dissolve_count = 0;
    video_count = 0;
    cycles = 0;
    frames_in = 0;
    verdicts_out = 0;
    thr_q = THR_RESET;
    level_q = LEVEL_RESET;
    limit_q = LIMIT_RESET;
    send_idle = 26;
    recv_idle = 56;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-frame video, then extremes, zero terms and dark runs
    add_frame(65535, 4194303, 1'b1);
    add_frame(0, 0, 1'b0);
    add_frame(65535, 4194303, 1'b0);
    add_frame(0, 0, 1'b0);
    add_frame(65535, 4194303, 1'b1);
    for (int k = 0; k < 14; k++)
      add_frame((k < 4) ? 100 : 1000 * k + 5000, 50 * k * k + 7, k == 13);
    add_frame(4000, 1000, 1'b0);
    add_frame(4000, 1000, 1'b0);
    add_frame(4000, 1000, 1'b1);
    random_videos(80);
    wait (frame_queue.size() < 10);
    hold_frames = 1'b1;
    wait (verdict_queue.size() == 0);
    hold_frames = 1'b0;
    drain();

    write_reg(CFG_RATIO_THRESHOLD, 31'd0);
    write_reg(CFG_DARK_LEVEL, 31'd0);
    write_reg(CFG_DARK_LIMIT, 31'd0);
    random_videos(40);
    drain();

    send_idle = 56;
    recv_idle = 26;
    write_reg(CFG_RATIO_THRESHOLD, 31'h7FFFFFFF);
    write_reg(CFG_DARK_LEVEL, 31'hFFFF);
    write_reg(CFG_DARK_LIMIT, 31'd16);
    random_videos(60);
    drain();

    write_reg(CFG_RATIO_THRESHOLD, 31'd1 << $urandom_range(30));
    write_reg(CFG_DARK_LEVEL, 31'd3000);
    write_reg(CFG_DARK_LIMIT, 31'd1);
    random_videos(70);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_RATIO_THRESHOLD, THR_RESET);
    write_reg(CFG_DARK_LEVEL, CFG_W'(LEVEL_RESET));
    write_reg(CFG_DARK_LIMIT, CFG_W'(LIMIT_RESET));
    random_videos(90);
    drain();

    $display("covered %0d videos over five register settings and three idle patterns",
             video_count);
    $display("checked %0d verdicts, %0d of them dissolves", verdict_count, dissolve_count);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
